FILE: design/dnd_pkg.sv
// dnd_pkg: constants, codes and types shared by the dns name decompressor
// depends on nothing
`timescale 1ns / 1ps
package dnd_pkg;
	localparam int PKT_BYTES    = 512;
	localparam int HEADER_BYTES = 12;
	localparam int NAME_MAX     = 255;
	localparam int AW           = $clog2(PKT_BYTES);
	localparam int LW           = AW + 1;
	localparam int NW           = $clog2(NAME_MAX + 1) + 1;

	localparam logic [7:0] PTR_MARK = 8'hc0;
	localparam logic [7:0] PTR_HIGH = 8'h3f;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADOFF   = 3'd1;
	localparam logic [2:0] ST_TRUNCPTR = 3'd2;
	localparam logic [2:0] ST_LOOP     = 3'd3;
	localparam logic [2:0] ST_TRUNCLBL = 3'd4;
	localparam logic [2:0] ST_LONG     = 3'd5;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       end_of_packet;
		logic [8:0] start_offset;
	} in_item_t;

	typedef struct packed {
		logic [7:0][7:0] chars;
		logic [3:0]      char_count;
		logic [2:0]      status;
		logic [9:0]      next_position;
		logic            last;
	} out_item_t;
endpackage

FILE: design/dnd_stream_if.sv
// dnd_stream_if: valid/ready channel carrying one payload item
// depends on nothing
`timescale 1ns / 1ps
interface dnd_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: design/dnd_ram.sv
// dnd_ram: generic single-port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

FILE: design/dns_name_decompressor.sv
// dns_name_decompressor: stores one dns packet and decodes compressed names out of it.
// Loads are accepted whenever the block is idle and never stall. A decode first runs a
// clearing pass over all PKT_BYTES entries of the visited-target ram, then checks the
// start offset, then walks the packet through the single ram port with registered read:
// each length or name byte is read and then evaluated, and a compression pointer reads
// both its bytes and looks its target up in the visited-target ram. Each full eight-byte
// result is sent, then the byte that did not fit is read again, and a result waits in the
// output register while the sink stalls. Input stays blocked until the last result of
// the decode has transferred. Depends on dnd_pkg, dnd_stream_if, dnd_ram
`timescale 1ns / 1ps
module dns_name_decompressor
	import dnd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	dnd_stream_if.sink   in_ch,
	dnd_stream_if.source out_ch
);
	localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_CHK = 4'd2, S_RD = 4'd3,
		S_EVAL = 4'd4, S_PRD = 4'd5, S_PEVAL = 4'd6, S_VRD = 4'd7, S_VEVAL = 4'd8,
		S_LRD = 4'd9, S_LEVAL = 4'd10, S_EMIT = 4'd11, S_WAIT = 4'd12;

	logic [3:0]  state_q;
	logic [LW-1:0] wr_idx_q, pkt_len_q, p_q, tgt_q, next_q;
	logic [7:0]  lbl_q, first_q;
	logic [NW-1:0] n_q;
	logic        labels_q, jumped_q, fin_q;
	logic [2:0]  stat_q;
	logic [7:0][7:0] buf_q;
	logic [3:0]  cnt_q;
	logic [AW-1:0] clr_q;
	out_item_t   out_q;
	logic        out_v_q;

	logic          pwe, vwe, vwd, vrd;
	logic [AW-1:0] paddr, vaddr;
	logic [7:0]    prd;

	dnd_ram #(.WIDTH(8), .DEPTH(PKT_BYTES)) u_pkt (.clk(clk), .we(pwe), .addr(paddr),
		.wdata(in_ch.payload.data_byte), .rdata(prd));
	dnd_ram #(.WIDTH(1), .DEPTH(PKT_BYTES)) u_vis (.clk(clk), .we(vwe), .addr(vaddr),
		.wdata(vwd), .rdata(vrd));

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.payload = out_q;

	wire in_xfer = in_ch.valid && in_ch.ready;
	wire is_load = in_ch.payload.func == FUNC_LOAD;
	// full 14-bit pointer target, range checked before it is narrowed
	wire [13:0] tgt_c = {first_q[5:0] & PTR_HIGH[5:0], prd};
	wire tgt_bad = (tgt_c < 14'(HEADER_BYTES)) || (tgt_c >= 14'(pkt_len_q));
	wire [LW-1:0] pb = p_q + LW'(prd);
	wire emit_go = (state_q == S_EMIT) && (!out_v_q || out_ch.ready);

	// ram address and write control
	always_comb begin
		pwe = in_xfer && is_load && (wr_idx_q < LW'(PKT_BYTES));
		paddr = pwe ? wr_idx_q[AW-1:0] : p_q[AW-1:0];
		vwe = (state_q == S_CLR) || (state_q == S_VEVAL && !vrd);
		vwd = (state_q != S_CLR);
		vaddr = (state_q == S_CLR) ? clr_q : tgt_q[AW-1:0];
	end

	function automatic logic bad(input logic [LW-1:0] x, input logic [LW-1:0] len);
		bad = (x < LW'(HEADER_BYTES)) || (x >= len);
	endfunction

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (emit_go) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	// sequencer over the packet ram port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; wr_idx_q <= '0; pkt_len_q <= '0;
			clr_q <= '0;
		end else begin
			case (state_q)
			S_IDLE: if (in_xfer) begin
				if (is_load) begin
					if (in_ch.payload.end_of_packet) begin
						pkt_len_q <= wr_idx_q + LW'(pwe); wr_idx_q <= '0;
					end else if (pwe) wr_idx_q <= wr_idx_q + 1'b1;
				end else begin
					p_q <= LW'(in_ch.payload.start_offset); n_q <= '0; cnt_q <= '0;
					labels_q <= 1'b0; jumped_q <= 1'b0; next_q <= '0; buf_q <= '0;
					lbl_q <= '0; clr_q <= '0; state_q <= S_CLR;
				end
			end
			S_CLR: begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(PKT_BYTES - 1)) state_q <= S_CHK;
			end
			S_CHK: if (bad(p_q, pkt_len_q)) begin
				stat_q <= ST_BADOFF; fin_q <= 1'b1; state_q <= S_EMIT;
			end else state_q <= S_RD;
			S_RD: state_q <= S_EVAL;
			S_EVAL: begin
				if (p_q >= pkt_len_q) begin
					stat_q <= ST_TRUNCLBL; fin_q <= 1'b1; state_q <= S_EMIT;
				end else if (prd >= PTR_MARK) begin
					if (p_q + 1'b1 >= pkt_len_q) begin
						stat_q <= ST_TRUNCPTR; fin_q <= 1'b1; state_q <= S_EMIT;
					end else begin
						first_q <= prd; p_q <= p_q + 1'b1; state_q <= S_PRD;
					end
				end else if (prd == 8'd0) begin
					if (!jumped_q) next_q <= p_q + 1'b1;
					stat_q <= ST_OK; fin_q <= 1'b1; state_q <= S_EMIT;
				end else if (pb >= pkt_len_q || pb < p_q) begin
					stat_q <= ST_TRUNCLBL; fin_q <= 1'b1; state_q <= S_EMIT;
				end else if (labels_q && n_q >= NW'(NAME_MAX)) begin
					stat_q <= ST_LONG; fin_q <= 1'b1; state_q <= S_EMIT;
				end else if (labels_q && cnt_q == 4'd8) begin
					// buffer full: send it, then look at this length byte again
					fin_q <= 1'b0; state_q <= S_EMIT;
				end else begin
					lbl_q <= prd; p_q <= p_q + 1'b1; labels_q <= 1'b1;
					state_q <= S_LRD;
					if (labels_q) begin
						buf_q[cnt_q[2:0]] <= 8'h2e; n_q <= n_q + 1'b1; cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			S_PRD: state_q <= S_PEVAL;
			S_PEVAL: begin
				tgt_q <= tgt_c[LW-1:0];
				if (!jumped_q) begin next_q <= p_q + 1'b1; jumped_q <= 1'b1; end
				if (tgt_bad) begin
					stat_q <= ST_BADOFF; fin_q <= 1'b1; state_q <= S_EMIT;
				end else state_q <= S_VRD;
			end
			S_VRD: state_q <= S_VEVAL;
			S_VEVAL: if (vrd) begin
				stat_q <= ST_LOOP; fin_q <= 1'b1; state_q <= S_EMIT;
			end else begin p_q <= tgt_q; state_q <= S_RD; end
			S_LRD: state_q <= S_LEVAL;
			S_LEVAL: begin
				if (n_q >= NW'(NAME_MAX)) begin
					stat_q <= ST_LONG; fin_q <= 1'b1; state_q <= S_EMIT;
				end else if (cnt_q == 4'd8) begin
					// buffer full: send it, then read this name byte again
					fin_q <= 1'b0; state_q <= S_EMIT;
				end else begin
					buf_q[cnt_q[2:0]] <= prd; n_q <= n_q + 1'b1; cnt_q <= cnt_q + 1'b1;
					p_q <= p_q + 1'b1; lbl_q <= lbl_q - 1'b1;
					state_q <= (lbl_q == 8'd1) ? S_RD : S_LRD;
				end
			end
			S_EMIT: if (emit_go) begin
				out_q.chars <= buf_q; out_q.char_count <= cnt_q;
				out_q.status <= fin_q ? stat_q : ST_OK;
				out_q.next_position <= (fin_q && stat_q == ST_OK) ? 10'(next_q) : 10'd0;
				out_q.last <= fin_q;
				buf_q <= '0; cnt_q <= '0;
				if (fin_q) state_q <= S_WAIT;
				else if (lbl_q == 8'd0) state_q <= S_RD;
				else state_q <= S_LRD;
			end
			S_WAIT: if (out_ch.ready || !out_v_q) state_q <= S_IDLE;
			default: state_q <= S_IDLE;
			endcase
		end
	end

	// finished results never exceed the name limit
	a_len: assert property (@(posedge clk) disable iff (!arst_n) n_q <= NW'(NAME_MAX) || state_q == S_IDLE)
		else $error("name length over limit");
	// no input taken while a decode is running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	// results carry at most eight bytes
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.char_count <= 4'd8) else $error("bad char count");
endmodule
